@@ sv/smps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sphere march pixel shader.
// No dependencies; the top level takes names from here by scope.
package smps_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 22;
  localparam int FRAME_W  = 9;
  localparam int FRAC_W   = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 9'd80;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 9'd24;

  localparam logic signed [COORD_W-1:0] POS_MAX = 24'sh7fffff;
  localparam logic signed [COORD_W-1:0] POS_MIN = 24'sh800000;

  // 5 * 37837, the light factor 0.57735 in Q0.16 times the five shade steps
  localparam logic [17:0] LIGHT5    = 18'd189185;
  localparam logic [3:0]  SHADE_MAX = 4'd9;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_SHADE  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_WR,
    ST_DSTART,
    ST_DWAIT,
    ST_S_RD,
    ST_S_LOAD,
    ST_MARCH,
    ST_MUL,
    ST_QINIT,
    ST_QLOOP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                 action;
    logic [2:0]                 ball_index;
    logic signed [COORD_W-1:0]  load_pos_x;
    logic signed [COORD_W-1:0]  load_pos_y;
    logic signed [COORD_W-1:0]  load_pos_z;
    logic signed [COORD_W-1:0]  load_vel_x;
    logic signed [COORD_W-1:0]  load_vel_y;
    logic signed [COORD_W-1:0]  load_vel_z;
    logic [RADIUS_W-1:0]        load_radius;
    logic signed [7:0]          pixel_x;
    logic signed [7:0]          pixel_y;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] shade;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic signed [COORD_W-1:0] vel_z;
    logic [RADIUS_W-1:0]       radius;
  } ball_t;

endpackage

@@ sv/smps_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/smps_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; divisor must be nonzero and held while busy.
module smps_div #(
  parameter int WIDTH = 11,
  parameter int DIVW  = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [DIVW-1:0]  divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [DIVW-1:0]  rem_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WIDTH-1:0] quo_q;
  logic [DIVW-1:0]  rem_q;
  logic [DIVW:0]    trial;
  logic [DIVW:0]    diff;
  logic             ge;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[WIDTH-2:0], ge};
      rem_q <= ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/sphere_march_pixel_shader_unit.sv @@
`timescale 1ns / 1ps
// Top level of the sphere march pixel shader: ball table, tick and shade engines.
// Depends on smps_pkg, smps_ram and smps_div.

// The ball table lives in one RAM, one entry per ball, with a valid bit per
// entry so that a never-written ball reads as all zero. A load writes its
// entry as it is accepted. A tick reads and writes back each ball in turn.
// A shade first runs four serial divisions (|x| and |x|*DEPTH_STEP, then y,
// by the frame width), and then marches each ball: it fetches the ball, steps
// one depth step per cycle through a three-stage test pipeline, drains it and
// closes the ball, and on the first hit forms the shade by repeated
// subtraction. New items are taken only in idle, but a finished result waits
// in its own output register without blocking input; a further shade result
// waits in ST_OUT until that register is free.
module sphere_march_pixel_shader_unit #(
  parameter int BALL_COUNT  = 5,
  parameter int DEPTH_LIMIT = 200,
  parameter int DEPTH_STEP  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [smps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smps_pkg::FRAME_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  smps_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output smps_pkg::out_t                      out_data_o
);

  localparam int BW   = BALL_COUNT > 1 ? $clog2(BALL_COUNT) : 1;
  localparam int SW   = $clog2(DEPTH_STEP + 1);
  localparam int DVW  = 8 + SW;                       // divider dividend width
  localparam int ZCW  = $clog2(DEPTH_LIMIT + DEPTH_STEP + 1);
  localparam int QW   = 8 + ZCW;                      // lateral quotient width
  localparam int IW   = QW + 14;                      // offset width before clip
  localparam int AW   = 48;                           // shade accumulator width
  localparam int FW   = smps_pkg::FRAME_W;
  localparam int CW   = smps_pkg::COORD_W;
  localparam int RW   = smps_pkg::RADIUS_W;
  localparam logic signed [25:0] ZBOUND = 26'(DEPTH_LIMIT * 4096);

  smps_pkg::state_e state_q, state_d;

  // Configuration
  logic [FW-1:0] fw_q, fh_q;
  logic [FW-1:0] wdiv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= smps_pkg::FRAME_WIDTH_RESET;
      fh_q <= smps_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smps_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_wdata_i;
        smps_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Zero width divides as one
  assign wdiv = (fw_q == '0) ? FW'(1) : fw_q;

  // Handshake
  logic in_xfer, out_xfer;
  assign in_ready_o = (state_q == smps_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Ball table
  logic [BALL_COUNT-1:0] valid_q;
  logic [BW-1:0]         b_q;
  logic                  rd_vld_q;
  logic                  last_ball;
  logic                  ram_we;
  logic [BW-1:0]         ram_waddr;
  smps_pkg::ball_t       ram_wdata, ram_rdata, rec, load_rec, tick_rec;
  logic                  do_load;

  assign last_ball = (b_q == BW'(BALL_COUNT - 1));
  assign do_load   = in_xfer && (in_data_i.action == smps_pkg::ACT_LOAD)
                     && (32'(in_data_i.ball_index) < BALL_COUNT);
  assign ram_we    = do_load || (state_q == smps_pkg::ST_T_WR);
  assign ram_waddr = (state_q == smps_pkg::ST_T_WR) ? b_q : BW'(in_data_i.ball_index);
  assign ram_wdata = (state_q == smps_pkg::ST_T_WR) ? tick_rec : load_rec;

  always_comb begin
    load_rec.pos_x  = in_data_i.load_pos_x;
    load_rec.pos_y  = in_data_i.load_pos_y;
    load_rec.pos_z  = in_data_i.load_pos_z;
    load_rec.vel_x  = in_data_i.load_vel_x;
    load_rec.vel_y  = in_data_i.load_vel_y;
    load_rec.vel_z  = in_data_i.load_vel_z;
    load_rec.radius = in_data_i.load_radius;
  end

  smps_ram #(
    .WIDTH ($bits(smps_pkg::ball_t)),
    .DEPTH (BALL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (b_q),
    .rdata_o (ram_rdata)
  );

  // Unwritten entries read as zero
  assign rec = rd_vld_q ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[b_q];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Tick arithmetic
  function automatic logic signed [CW-1:0] neg_sat(input logic signed [CW-1:0] v);
    if (v == smps_pkg::POS_MIN) return smps_pkg::POS_MAX;
    return -v;
  endfunction

  function automatic logic signed [CW-1:0] add_sat(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) return s[CW] ? smps_pkg::POS_MIN : smps_pkg::POS_MAX;
    return s[CW-1:0];
  endfunction

  logic signed [25:0] wb, hb, px_e, py_e, pz_e, r_e;
  logic               flip_x, flip_y, flip_z;
  logic signed [CW-1:0] nvx, nvy, nvz;

  always_comb begin
    wb   = $signed({5'b0, fw_q, 12'b0});
    hb   = $signed({5'b0, fh_q, 12'b0});
    px_e = {{2{rec.pos_x[CW-1]}}, rec.pos_x};
    py_e = {{2{rec.pos_y[CW-1]}}, rec.pos_y};
    pz_e = {{2{rec.pos_z[CW-1]}}, rec.pos_z};
    r_e  = $signed({4'b0, rec.radius});
    flip_x = (px_e <= -wb) || (px_e >= wb);
    flip_y = (py_e <= -hb) || (py_e >= hb);
    flip_z = (pz_e <= r_e) || (pz_e >= ZBOUND);
    nvx = flip_x ? neg_sat(rec.vel_x) : rec.vel_x;
    nvy = flip_y ? neg_sat(rec.vel_y) : rec.vel_y;
    nvz = flip_z ? neg_sat(rec.vel_z) : rec.vel_z;
    tick_rec.vel_x  = nvx;
    tick_rec.vel_y  = nvy;
    tick_rec.vel_z  = nvz;
    tick_rec.pos_x  = add_sat(rec.pos_x, nvx);
    tick_rec.pos_y  = add_sat(rec.pos_y, nvy);
    tick_rec.pos_z  = add_sat(rec.pos_z, nvz);
    tick_rec.radius = rec.radius;
  end

  // Pixel setup: |x|, |y| and their per-step quotients by the frame width
  logic [7:0]     ax_q, ay_q;
  logic           sx_q, sy_q;
  logic [1:0]     dsel_q;
  logic           div_start, div_done;
  logic [DVW-1:0] div_dividend, div_quot;
  logic [FW-1:0]  div_rem;
  logic [DVW-1:0] qx1_q, qxs_q, qy1_q, qys_q;
  logic [FW-1:0]  rx1_q, rxs_q, ry1_q, rys_q;

  always_comb begin
    case (dsel_q)
      2'd0:    div_dividend = DVW'(ax_q);
      2'd1:    div_dividend = DVW'(32'(ax_q) * DEPTH_STEP);
      2'd2:    div_dividend = DVW'(ay_q);
      default: div_dividend = DVW'(32'(ay_q) * DEPTH_STEP);
    endcase
  end

  assign div_start = (state_q == smps_pkg::ST_DSTART);

  smps_div #(
    .WIDTH (DVW),
    .DIVW  (FW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (wdiv),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // March accumulators: lateral quotient and remainder of |x|*z/w, stepped
  logic [QW-1:0]  lqx_q, lqy_q;
  logic [FW-1:0]  lrx_q, lry_q;
  logic [ZCW-1:0] z_q;
  logic [FW:0]    rsx, rsy;
  logic           wrx, wry;
  logic signed [CW-1:0] bpx_q, bpy_q, bpz_q;
  logic [RW-1:0]  br_q;
  logic [2*RW-1:0] r2_q;

  assign rsx = {1'b0, lrx_q} + {1'b0, rxs_q};
  assign rsy = {1'b0, lry_q} + {1'b0, rys_q};
  assign wrx = rsx >= {1'b0, wdiv};
  assign wry = rsy >= {1'b0, wdiv};

  // Test pipeline
  logic issue, advance, hit_now;
  logic v1_q, v2_q;

  function automatic logic [IW-1:0] absv(input logic signed [IW-1:0] v);
    return v[IW-1] ? IW'(-v) : IW'(v);
  endfunction

  logic signed [IW-1:0] lx, ly, ix, iy, iz;
  logic [IW-1:0]        mx, my, mz;
  logic                 big1;

  always_comb begin
    lx = $signed({{(IW-QW){1'b0}}, lqx_q});
    ly = $signed({{(IW-QW){1'b0}}, lqy_q});
    if (sx_q) lx = -lx;
    if (sy_q) ly = -ly;
    ix = (lx <<< 12) - $signed({{(IW-CW){bpx_q[CW-1]}}, bpx_q});
    iy = (ly <<< 12) - $signed({{(IW-CW){bpy_q[CW-1]}}, bpy_q});
    iz = $signed({{(IW-ZCW-12){1'b0}}, z_q, 12'b0})
         - $signed({{(IW-CW){bpz_q[CW-1]}}, bpz_q});
    mx = absv(ix);
    my = absv(iy);
    mz = absv(iz);
    // An offset of 2^22 or more is already outside any radius
    big1 = (|mx[IW-1:RW]) || (|my[IW-1:RW]) || (|mz[IW-1:RW]);
  end

  logic [RW-1:0]        mx1_q, my1_q, mz1_q;
  logic signed [CW-1:0] ix1_q, iy1_q, iz1_q;
  logic                 big1_q;
  logic [2*RW-1:0]      sqx_q, sqy_q, sqz_q;
  logic signed [25:0]   s2_q;
  logic                 big2_q;
  logic [2*RW+1:0]      dist2;

  assign dist2   = (2*RW+2)'(sqx_q) + (2*RW+2)'(sqy_q) + (2*RW+2)'(sqz_q);
  assign hit_now = (state_q == smps_pkg::ST_MARCH) && v2_q && !big2_q
                   && (dist2 < {2'b0, r2_q});
  assign advance = (state_q == smps_pkg::ST_MARCH) && !hit_now;
  assign issue   = advance && (32'(z_q) < DEPTH_LIMIT);

  // Shade: count multiples of R = r<<16 below 5*c*s + 5*R
  logic signed [44:0]   t_q;
  logic signed [AW-1:0] acc_q;
  logic [3:0]           q_q;
  logic [AW-1:0]        rbig;
  logic                 hit_acc_q;
  logic [3:0]           shade_acc_q;

  assign rbig = AW'({br_q, 16'b0});

  // Output register
  logic            out_valid_q;
  smps_pkg::out_t  out_q;
  logic            out_load;

  assign out_load = (state_q == smps_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_xfer = out_valid_q && out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smps_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_data_i.action)
            smps_pkg::ACT_TICK:  state_d = smps_pkg::ST_T_RD;
            smps_pkg::ACT_SHADE: state_d = smps_pkg::ST_DSTART;
            default:             state_d = smps_pkg::ST_IDLE;
          endcase
        end
      end
      smps_pkg::ST_T_RD:   state_d = smps_pkg::ST_T_WR;
      smps_pkg::ST_T_WR:   state_d = last_ball ? smps_pkg::ST_IDLE : smps_pkg::ST_T_RD;
      smps_pkg::ST_DSTART: state_d = smps_pkg::ST_DWAIT;
      smps_pkg::ST_DWAIT: begin
        if (div_done) begin
          state_d = (dsel_q == 2'd3) ? smps_pkg::ST_S_RD : smps_pkg::ST_DSTART;
        end
      end
      smps_pkg::ST_S_RD:   state_d = smps_pkg::ST_S_LOAD;
      smps_pkg::ST_S_LOAD: state_d = smps_pkg::ST_MARCH;
      smps_pkg::ST_MARCH: begin
        if (hit_now) begin
          state_d = smps_pkg::ST_MUL;
        end else if (!issue && !v1_q && !v2_q) begin
          state_d = last_ball ? smps_pkg::ST_OUT : smps_pkg::ST_S_RD;
        end
      end
      smps_pkg::ST_MUL:   state_d = smps_pkg::ST_QINIT;
      smps_pkg::ST_QINIT: state_d = smps_pkg::ST_QLOOP;
      smps_pkg::ST_QLOOP: begin
        if (acc_q[AW-1] || q_q == smps_pkg::SHADE_MAX) begin
          state_d = last_ball ? smps_pkg::ST_OUT : smps_pkg::ST_S_RD;
        end
      end
      smps_pkg::ST_OUT: begin
        if (out_load) state_d = smps_pkg::ST_IDLE;
      end
      default: state_d = smps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  logic ball_done;
  assign ball_done = ((state_q == smps_pkg::ST_MARCH) && !hit_now && !issue && !v1_q && !v2_q)
                     || ((state_q == smps_pkg::ST_QLOOP)
                         && (acc_q[AW-1] || q_q == smps_pkg::SHADE_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q         <= '0;
      dsel_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      hit_acc_q   <= 1'b0;
      shade_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        b_q         <= '0;
        dsel_q      <= '0;
        hit_acc_q   <= 1'b0;
        shade_acc_q <= '0;
      end
      if ((state_q == smps_pkg::ST_T_WR || ball_done) && !last_ball) begin
        b_q <= b_q + 1'b1;
      end
      if (state_q == smps_pkg::ST_DWAIT && div_done) begin
        dsel_q <= dsel_q + 1'b1;
      end
      if (advance) begin
        v1_q <= issue;
        v2_q <= v1_q;
      end else begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end
      // A later ball's hit overwrites an earlier one
      if (state_q == smps_pkg::ST_QLOOP && (acc_q[AW-1] || q_q == smps_pkg::SHADE_MAX)) begin
        hit_acc_q   <= 1'b1;
        shade_acc_q <= q_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sx_q <= in_data_i.pixel_x[7];
      sy_q <= in_data_i.pixel_y[7];
      ax_q <= in_data_i.pixel_x[7] ? 8'(-in_data_i.pixel_x) : in_data_i.pixel_x;
      ay_q <= in_data_i.pixel_y[7] ? 8'(-in_data_i.pixel_y) : in_data_i.pixel_y;
    end
    if (state_q == smps_pkg::ST_DWAIT && div_done) begin
      case (dsel_q)
        2'd0:    begin qx1_q <= div_quot; rx1_q <= div_rem; end
        2'd1:    begin qxs_q <= div_quot; rxs_q <= div_rem; end
        2'd2:    begin qy1_q <= div_quot; ry1_q <= div_rem; end
        default: begin qys_q <= div_quot; rys_q <= div_rem; end
      endcase
    end
    if (state_q == smps_pkg::ST_S_LOAD) begin
      bpx_q <= rec.pos_x;
      bpy_q <= rec.pos_y;
      bpz_q <= rec.pos_z;
      br_q  <= rec.radius;
      r2_q  <= rec.radius * rec.radius;
      lqx_q <= QW'(qx1_q);
      lqy_q <= QW'(qy1_q);
      lrx_q <= rx1_q;
      lry_q <= ry1_q;
      z_q   <= ZCW'(1);
    end
    if (issue) begin
      lqx_q  <= lqx_q + QW'(qxs_q) + QW'(wrx);
      lqy_q  <= lqy_q + QW'(qys_q) + QW'(wry);
      lrx_q  <= wrx ? FW'(rsx - {1'b0, wdiv}) : rsx[FW-1:0];
      lry_q  <= wry ? FW'(rsy - {1'b0, wdiv}) : rsy[FW-1:0];
      z_q    <= z_q + ZCW'(DEPTH_STEP);
    end
    if (advance) begin
      mx1_q  <= mx[RW-1:0];
      my1_q  <= my[RW-1:0];
      mz1_q  <= mz[RW-1:0];
      ix1_q  <= ix[CW-1:0];
      iy1_q  <= iy[CW-1:0];
      iz1_q  <= iz[CW-1:0];
      big1_q <= big1;
      sqx_q  <= mx1_q * mx1_q;
      sqy_q  <= my1_q * my1_q;
      sqz_q  <= mz1_q * mz1_q;
      s2_q   <= 26'(ix1_q) - 26'(iy1_q) - 26'(iz1_q);
      big2_q <= big1_q;
    end
    if (state_q == smps_pkg::ST_MUL) begin
      t_q <= s2_q * $signed({1'b0, smps_pkg::LIGHT5});
    end
    if (state_q == smps_pkg::ST_QINIT) begin
      acc_q <= AW'(t_q) + $signed(rbig << 2);
      q_q   <= '0;
    end
    if (state_q == smps_pkg::ST_QLOOP && !acc_q[AW-1] && q_q != smps_pkg::SHADE_MAX) begin
      acc_q <= acc_q - $signed(rbig);
      q_q   <= q_q + 1'b1;
    end
    if (out_load) begin
      out_q.hit   <= hit_acc_q;
      out_q.shade <= shade_acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_pipe_in_march: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> state_q == smps_pkg::ST_MARCH)
    else $error("march pipeline busy outside march");

  a_shade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_acc_q <= smps_pkg::SHADE_MAX)
    else $error("shade out of range");

  a_miss_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |-> out_data_o.shade == 4'd0)
    else $error("miss with nonzero shade");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == smps_pkg::ST_DWAIT)
    else $error("divider finished outside setup");

endmodule
